// ----- rtl/core/c8ic_pkg.sv -----
// shared types, constants and the opcode decoder of the chip-8 instruction core
// used by c8ic_ctrl, c8ic_dpath and chip8_instruction_core
package c8ic_pkg;

  localparam int unsigned MemBytesDef   = 4096;
  localparam int unsigned StackDepthDef = 16;
  localparam int unsigned ScreenW       = 64;
  localparam int unsigned ScreenH       = 32;
  // width of a memory address before the wrap (index plus offset)
  localparam int unsigned SrcW          = 17;

  localparam logic [11:0] PcReset = 12'h200;

  // word operations
  localparam logic [1:0] OpWrite = 2'd0;
  localparam logic [1:0] OpExec  = 2'd1;
  localparam logic [1:0] OpPixel = 2'd2;

  // low-byte codes of the opcode families
  localparam logic [7:0] NnCls   = 8'hE0;
  localparam logic [7:0] NnRet   = 8'hEE;
  localparam logic [7:0] NnSkp   = 8'h9E;
  localparam logic [7:0] NnSknp  = 8'hA1;
  localparam logic [7:0] NnGetDt = 8'h07;
  localparam logic [7:0] NnSetDt = 8'h15;
  localparam logic [7:0] NnAddI  = 8'h1E;
  localparam logic [7:0] NnBcd   = 8'h33;
  localparam logic [7:0] NnStore = 8'h55;
  localparam logic [7:0] NnLoad  = 8'h65;

  // alu sub-operations of the 8XYn family
  localparam logic [3:0] AluMov = 4'h0;
  localparam logic [3:0] AluOr  = 4'h1;
  localparam logic [3:0] AluAnd = 4'h2;
  localparam logic [3:0] AluXor = 4'h3;
  localparam logic [3:0] AluAdd = 4'h4;
  localparam logic [3:0] AluSub = 4'h5;
  localparam logic [3:0] AluShr = 4'h6;
  localparam logic [3:0] AluSbn = 4'h7;
  localparam logic [3:0] AluShl = 4'hE;

  typedef enum logic [4:0] {
    K_CLS, K_RET, K_JP, K_CALL, K_SKIP, K_LD, K_ADD, K_ALU, K_LDI,
    K_DRW, K_LDDT, K_SETDT, K_ADDI, K_BCD, K_STR, K_LDR, K_UNK
  } kind_e;

  typedef enum logic [1:0] {AM_IN, AM_PC, AM_PC1, AM_IDX} am_sel_e;
  typedef enum logic [1:0] {RS_X, RS_Y, RS_CNT} rf_sel_e;
  typedef enum logic [1:0] {MW_DATA, MW_BCD, MW_REG} mw_sel_e;

  typedef struct packed {
    logic    clr_wr;
    logic    latch_in;
    logic    am_load;
    am_sel_e am_sel;
    logic    mem_we;
    mw_sel_e mw_sel;
    logic    mem_re;
    logic    cap_hi;
    logic    cap_lo;
    logic    rf_re;
    rf_sel_e rf_sel;
    logic    cap_vx;
    logic    cap_vy;
    logic    exec;
    logic    alu_flag_wr;
    logic    ret_load;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    ldr_wr;
    logic    fb_rd_pix;
    logic    cap_pix;
    logic    fb_rd_draw;
    logic    draw_wr;
    logic    coll_wr;
    logic    tick;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    kind_e      kind;
    logic       alu_flag;
    logic       clr_last;
    logic       cnt_eq_x;
    logic       cnt_eq_2;
    logic       cnt_eq_nlast;
    logic       n_zero;
  } stat_t;

  function automatic kind_e decode(input logic [15:0] w);
    kind_e k;
    k = K_UNK;
    unique case (w[15:12])
      4'h0: begin
        if (w[7:0] == NnCls) k = K_CLS;
        else if (w[7:0] == NnRet) k = K_RET;
      end
      4'h1: k = K_JP;
      4'h2: k = K_CALL;
      4'h3, 4'h4, 4'h5, 4'h9: k = K_SKIP;
      4'h6: k = K_LD;
      4'h7: k = K_ADD;
      4'h8: begin
        if (w[3:0] <= AluSbn || w[3:0] == AluShl) k = K_ALU;
      end
      4'hA: k = K_LDI;
      4'hD: k = K_DRW;
      4'hE: begin
        if (w[7:0] == NnSkp || w[7:0] == NnSknp) k = K_SKIP;
      end
      4'hF: begin
        unique case (w[7:0])
          NnGetDt: k = K_LDDT;
          NnSetDt: k = K_SETDT;
          NnAddI:  k = K_ADDI;
          NnBcd:   k = K_BCD;
          NnStore: k = K_STR;
          NnLoad:  k = K_LDR;
          default: k = K_UNK;
        endcase
      end
      default: k = K_UNK;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/core/c8ic_dpath.sv -----
// datapath of the chip-8 instruction core: memories, registers, alu, address wrap
// depends on c8ic_pkg; driven by commands from c8ic_ctrl
module c8ic_dpath #(
  parameter int unsigned MEM_BYTES   = c8ic_pkg::MemBytesDef,
  parameter int unsigned STACK_DEPTH = c8ic_pkg::StackDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  c8ic_pkg::cmd_t     cmd_i,
  output c8ic_pkg::stat_t    stat_o,
  input  logic [1:0]         operation_i,
  input  logic [11:0]        address_i,
  input  logic [7:0]         data_i,
  input  logic [15:0]        key_state_i,
  output logic [11:0]        pc_value_o,
  output logic [15:0]        fetched_opcode_o,
  output logic               pixel_o,
  output logic               halted_o,
  output logic               drew_o,
  output logic               unknown_opcode_o
);

  localparam int unsigned AW    = $clog2(MEM_BYTES);
  localparam int unsigned SW    = $clog2(STACK_DEPTH);
  localparam int unsigned SrcW  = c8ic_pkg::SrcW;
  localparam int unsigned Recip = (1 << c8ic_pkg::SrcW) / MEM_BYTES;
  localparam int unsigned RW    = $clog2(Recip + 1);
  localparam int unsigned ScreenW = c8ic_pkg::ScreenW;
  localparam int unsigned ScreenH = c8ic_pkg::ScreenH;

  // captured word
  logic [1:0]  op_q;
  logic [11:0] addr_in_q;
  logic [7:0]  data_q;
  logic [15:0] keys_q;

  // architectural state
  logic [11:0]   pc_q;
  logic [15:0]   i_q;
  logic [SW-1:0] sp_q;
  logic [7:0]    dt_q;
  logic          halt_q;
  logic [AW-1:0] clr_cnt_q;
  logic [15:0]   rf_vld_q;
  logic [ScreenH-1:0] fb_vld_q;

  // working registers
  logic [15:0] opcode_q;
  logic [7:0]  vx_q, vy_q;
  logic [3:0]  cnt_q;
  logic        flag_q, coll_q, pix_q;
  logic [SrcW-1:0] am_a_q;
  logic [RW-1:0]   am_q_q;

  c8ic_pkg::kind_e kind_w;
  logic [3:0]  x_w, y_w, n_w;
  logic [7:0]  nn_w;
  logic [11:0] nnn_w;

  assign kind_w = c8ic_pkg::decode(opcode_q);
  assign x_w    = opcode_q[11:8];
  assign y_w    = opcode_q[7:4];
  assign n_w    = opcode_q[3:0];
  assign nn_w   = opcode_q[7:0];
  assign nnn_w  = opcode_q[11:0];

  // address wrap: reciprocal multiply, then one subtract step
  logic [SrcW-1:0]    am_src;
  logic [SrcW+RW-1:0] am_prod;
  logic [SrcW:0]      am_qm, am_r, am_rf;
  logic [AW-1:0]      mod_addr;

  always_comb begin
    unique case (cmd_i.am_sel)
      c8ic_pkg::AM_IN:  am_src = SrcW'(addr_in_q);
      c8ic_pkg::AM_PC:  am_src = SrcW'(pc_q);
      c8ic_pkg::AM_PC1: am_src = SrcW'(pc_q) + SrcW'(1);
      default:          am_src = SrcW'(i_q) + SrcW'(cnt_q);
    endcase
  end

  assign am_prod  = (SrcW+RW)'(am_a_q) * (SrcW+RW)'(Recip);
  assign am_qm    = (SrcW+1)'(am_q_q) * (SrcW+1)'(MEM_BYTES);
  assign am_r     = (SrcW+1)'(am_a_q) - am_qm;
  assign am_rf    = (am_r >= (SrcW+1)'(MEM_BYTES)) ? am_r - (SrcW+1)'(MEM_BYTES) : am_r;
  assign mod_addr = am_rf[AW-1:0];

  // register file reads
  logic [7:0] rf [16];
  logic [7:0] rf_data_q, rf_rd;
  logic       rf_hit_q;
  logic [3:0] rf_ra;

  always_comb begin
    unique case (cmd_i.rf_sel)
      c8ic_pkg::RS_X: rf_ra = x_w;
      c8ic_pkg::RS_Y: rf_ra = y_w;
      default:        rf_ra = cnt_q;
    endcase
  end
  assign rf_rd = rf_hit_q ? rf_data_q : 8'h00;

  // alu
  logic [8:0] sum9;
  logic [7:0] alu_res;
  logic       alu_flag;

  assign sum9 = {1'b0, vx_q} + {1'b0, vy_q};

  always_comb begin
    alu_res  = vy_q;
    alu_flag = 1'b0;
    case (n_w)
      c8ic_pkg::AluMov: alu_res = vy_q;
      c8ic_pkg::AluOr:  alu_res = vx_q | vy_q;
      c8ic_pkg::AluAnd: alu_res = vx_q & vy_q;
      c8ic_pkg::AluXor: alu_res = vx_q ^ vy_q;
      c8ic_pkg::AluAdd: begin alu_res = sum9[7:0]; alu_flag = sum9[8]; end
      c8ic_pkg::AluSub: begin alu_res = vx_q - vy_q; alu_flag = (vx_q >= vy_q); end
      c8ic_pkg::AluShr: begin alu_res = {1'b0, vx_q[7:1]}; alu_flag = vx_q[0]; end
      c8ic_pkg::AluSbn: begin alu_res = vy_q - vx_q; alu_flag = (vy_q >= vx_q); end
      c8ic_pkg::AluShl: begin alu_res = {vx_q[6:0], 1'b0}; alu_flag = vx_q[7]; end
      default: ;
    endcase
  end

  // skip condition
  logic skip_w, key_w;
  assign key_w = keys_q[vx_q[3:0]];

  always_comb begin
    case (opcode_q[15:12])
      4'h3:    skip_w = (vx_q == nn_w);
      4'h4:    skip_w = (vx_q != nn_w);
      4'h5:    skip_w = (vx_q == vy_q);
      4'h9:    skip_w = (vx_q != vy_q);
      4'hE:    skip_w = (nn_w == c8ic_pkg::NnSkp) ? key_w : !key_w;
      default: skip_w = 1'b0;
    endcase
  end

  // bcd digits
  logic [1:0]  bcd_h;
  logic [7:0]  bcd_rem8;
  logic [6:0]  bcd_rem;
  logic [14:0] bcd_tp;
  logic [3:0]  bcd_t, bcd_o;
  logic [7:0]  bcd_digit;

  always_comb begin
    if (vx_q >= 8'd200) begin
      bcd_h = 2'd2; bcd_rem8 = vx_q - 8'd200;
    end else if (vx_q >= 8'd100) begin
      bcd_h = 2'd1; bcd_rem8 = vx_q - 8'd100;
    end else begin
      bcd_h = 2'd0; bcd_rem8 = vx_q;
    end
    bcd_rem = bcd_rem8[6:0];
    bcd_tp  = 15'(bcd_rem) * 15'd205;
    bcd_t   = bcd_tp[14:11];
    bcd_o   = 4'(bcd_rem - 7'(bcd_t) * 7'd10);
    case (cnt_q[1:0])
      2'd0:    bcd_digit = {6'h00, bcd_h};
      2'd1:    bcd_digit = {4'h0, bcd_t};
      default: bcd_digit = {4'h0, bcd_o};
    endcase
  end

  // program memory
  logic [7:0]    pmem [MEM_BYTES];
  logic [7:0]    mem_rd_q, mem_wdata;
  logic [AW-1:0] mem_addr;

  assign mem_addr = cmd_i.clr_wr ? clr_cnt_q : mod_addr;

  always_comb begin
    case (cmd_i.mw_sel)
      c8ic_pkg::MW_BCD: mem_wdata = bcd_digit;
      c8ic_pkg::MW_REG: mem_wdata = rf_rd;
      default:          mem_wdata = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr || cmd_i.mem_we) begin
      pmem[mem_addr] <= cmd_i.clr_wr ? 8'h00 : mem_wdata;
    end
    if (cmd_i.mem_re) begin
      mem_rd_q <= pmem[mem_addr];
    end
  end

  // frame buffer, one row of pixels per entry
  logic [ScreenW-1:0] fb [ScreenH];
  logic [ScreenW-1:0] fb_rd_q, fb_old, mask;
  logic               fb_hit_q;
  logic [4:0]         draw_row, fb_row;
  logic               pix_pick;

  assign draw_row = vy_q[4:0] + {1'b0, cnt_q};
  assign fb_row   = cmd_i.fb_rd_pix ? addr_in_q[10:6] : draw_row;
  assign fb_old   = fb_hit_q ? fb_rd_q : '0;
  assign pix_pick = fb_hit_q ? fb_rd_q[addr_in_q[5:0]] : 1'b0;

  always_comb begin
    mask = '0;
    for (int k = 0; k < 8; k++) begin
      mask[6'(vx_q[5:0] + 6'(k))] = mem_rd_q[7-k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fb_rd_pix || cmd_i.fb_rd_draw) begin
      fb_rd_q  <= fb[fb_row];
      fb_hit_q <= fb_vld_q[fb_row];
    end
    if (cmd_i.draw_wr) begin
      fb[draw_row] <= fb_old ^ mask;
    end
  end

  // return stack
  logic [11:0]   stk [STACK_DEPTH];
  logic [11:0]   stk_rd_q;
  logic [SW-1:0] sp_inc, sp_dec;

  assign sp_inc = (sp_q == SW'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
  assign sp_dec = (sp_q == '0) ? SW'(STACK_DEPTH - 1) : sp_q - 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && kind_w == c8ic_pkg::K_CALL) stk[sp_q] <= pc_q;
    if (cmd_i.exec && kind_w == c8ic_pkg::K_RET) stk_rd_q <= stk[sp_dec];
  end

  // register file write port
  logic       rf_we;
  logic [3:0] rf_wa;
  logic [7:0] rf_wd;

  always_comb begin
    rf_we = 1'b0;
    rf_wa = x_w;
    rf_wd = alu_res;
    if (cmd_i.exec) begin
      case (kind_w)
        c8ic_pkg::K_LD:   begin rf_we = 1'b1; rf_wd = nn_w; end
        c8ic_pkg::K_ADD:  begin rf_we = 1'b1; rf_wd = vx_q + nn_w; end
        c8ic_pkg::K_ALU:  begin rf_we = 1'b1; rf_wd = alu_res; end
        c8ic_pkg::K_LDDT: begin rf_we = 1'b1; rf_wd = dt_q; end
        default: ;
      endcase
    end
    if (cmd_i.alu_flag_wr) begin
      rf_we = 1'b1; rf_wa = 4'hF; rf_wd = {7'h00, flag_q};
    end
    if (cmd_i.ldr_wr) begin
      rf_we = 1'b1; rf_wa = cnt_q; rf_wd = mem_rd_q;
    end
    if (cmd_i.coll_wr) begin
      rf_we = 1'b1; rf_wa = 4'hF; rf_wd = {7'h00, coll_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
    if (cmd_i.rf_re) begin
      rf_data_q <= rf[rf_ra];
      rf_hit_q  <= rf_vld_q[rf_ra];
    end
  end

  // architectural state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= c8ic_pkg::PcReset;
      i_q       <= '0;
      sp_q      <= '0;
      dt_q      <= '0;
      halt_q    <= 1'b0;
      clr_cnt_q <= '0;
      rf_vld_q  <= '0;
      fb_vld_q  <= '0;
    end else begin
      if (cmd_i.clr_wr) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (rf_we) rf_vld_q[rf_wa] <= 1'b1;
      if (cmd_i.draw_wr) fb_vld_q[draw_row] <= 1'b1;
      if (cmd_i.exec) begin
        unique case (kind_w)
          c8ic_pkg::K_CLS: begin
            fb_vld_q <= '0;
            pc_q     <= pc_q + 12'd2;
          end
          c8ic_pkg::K_RET: sp_q <= sp_dec;
          c8ic_pkg::K_JP: begin
            if (nnn_w == pc_q) halt_q <= 1'b1;
            else pc_q <= nnn_w;
          end
          c8ic_pkg::K_CALL: begin
            sp_q <= sp_inc;
            pc_q <= nnn_w;
          end
          c8ic_pkg::K_SKIP: pc_q <= pc_q + (skip_w ? 12'd4 : 12'd2);
          c8ic_pkg::K_LDI: begin
            i_q  <= {4'h0, nnn_w};
            pc_q <= pc_q + 12'd2;
          end
          c8ic_pkg::K_ADDI: begin
            i_q  <= i_q + {8'h00, vx_q};
            pc_q <= pc_q + 12'd2;
          end
          c8ic_pkg::K_SETDT: begin
            dt_q <= vx_q;
            pc_q <= pc_q + 12'd2;
          end
          default: pc_q <= pc_q + 12'd2;
        endcase
      end
      if (cmd_i.ret_load) pc_q <= stk_rd_q + 12'd2;
      if (cmd_i.tick && dt_q != 8'h00) dt_q <= dt_q - 8'd1;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q      <= operation_i;
      addr_in_q <= address_i;
      data_q    <= data_i;
      keys_q    <= key_state_i;
      pix_q     <= 1'b0;
    end
    if (cmd_i.am_load) am_a_q <= am_src;
    am_q_q <= am_prod[SrcW+RW-1:SrcW];
    if (cmd_i.cap_hi) opcode_q[15:8] <= mem_rd_q;
    if (cmd_i.cap_lo) opcode_q[7:0] <= mem_rd_q;
    if (cmd_i.cap_vx) vx_q <= rf_rd;
    if (cmd_i.cap_vy) vy_q <= rf_rd;
    if (cmd_i.cap_pix) pix_q <= pix_pick;
    if (cmd_i.exec) begin
      flag_q <= alu_flag;
      coll_q <= 1'b0;
    end
    if (cmd_i.draw_wr) coll_q <= coll_q | (|(fb_old & mask));
    if (cmd_i.cnt_clr) cnt_q <= '0;
    else if (cmd_i.cnt_inc) cnt_q <= cnt_q + 4'd1;
  end

  // result register
  logic is_exec;
  assign is_exec = (op_q == c8ic_pkg::OpExec);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pc_value_o       <= pc_q;
      fetched_opcode_o <= is_exec ? opcode_q : 16'h0000;
      pixel_o          <= pix_q;
      halted_o         <= halt_q;
      drew_o           <= is_exec && kind_w == c8ic_pkg::K_DRW;
      unknown_opcode_o <= is_exec && kind_w == c8ic_pkg::K_UNK;
    end
  end

  // status to the controller
  assign stat_o.op           = op_q;
  assign stat_o.kind         = kind_w;
  assign stat_o.alu_flag     = (n_w == c8ic_pkg::AluAdd) || (n_w == c8ic_pkg::AluSub) ||
                               (n_w == c8ic_pkg::AluShr) || (n_w == c8ic_pkg::AluSbn) ||
                               (n_w == c8ic_pkg::AluShl);
  assign stat_o.clr_last     = (clr_cnt_q == AW'(MEM_BYTES - 1));
  assign stat_o.cnt_eq_x     = (cnt_q == x_w);
  assign stat_o.cnt_eq_2     = (cnt_q == 4'd2);
  assign stat_o.cnt_eq_nlast = (cnt_q == n_w - 4'd1);
  assign stat_o.n_zero       = (n_w == 4'd0);

endmodule

// ----- rtl/core/c8ic_ctrl.sv -----
// sequencer of the chip-8 instruction core: handshakes and micro-steps
// depends on c8ic_pkg; drives c8ic_dpath through cmd_t
module c8ic_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      operation_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  c8ic_pkg::stat_t stat_i,
  output c8ic_pkg::cmd_t  cmd_o
);

  localparam logic [5:0] S_CLR = 6'd0,  S_IDLE = 6'd1,  S_WA  = 6'd2,  S_WW  = 6'd3;
  localparam logic [5:0] S_WM  = 6'd4,  S_PX0  = 6'd5,  S_PX1 = 6'd6,  S_F0A = 6'd7;
  localparam logic [5:0] S_F0W = 6'd8,  S_F0M  = 6'd9,  S_F1A = 6'd10, S_F1W = 6'd11;
  localparam logic [5:0] S_F1M = 6'd12, S_FLO  = 6'd13, S_RX  = 6'd14, S_RY  = 6'd15;
  localparam logic [5:0] S_RV  = 6'd16, S_EX   = 6'd17, S_RT  = 6'd18, S_AF  = 6'd19;
  localparam logic [5:0] S_BA  = 6'd20, S_BW   = 6'd21, S_BM  = 6'd22, S_SA  = 6'd23;
  localparam logic [5:0] S_SW  = 6'd24, S_SM   = 6'd25, S_LA  = 6'd26, S_LW  = 6'd27;
  localparam logic [5:0] S_LM  = 6'd28, S_LR   = 6'd29, S_DA  = 6'd30, S_DW  = 6'd31;
  localparam logic [5:0] S_DM  = 6'd32, S_DX   = 6'd33, S_DE  = 6'd34, S_TK  = 6'd35;
  localparam logic [5:0] S_DN  = 6'd36;

  logic [5:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.am_sel = c8ic_pkg::AM_IDX;
    cmd_o.mw_sel = c8ic_pkg::MW_DATA;
    cmd_o.rf_sel = c8ic_pkg::RS_X;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          case (operation_i)
            c8ic_pkg::OpWrite: state_d = S_WA;
            c8ic_pkg::OpExec:  state_d = S_F0A;
            c8ic_pkg::OpPixel: state_d = S_PX0;
            default:           state_d = S_DN;
          endcase
        end
      end
      S_WA: begin
        cmd_o.am_load = 1'b1;
        cmd_o.am_sel  = c8ic_pkg::AM_IN;
        state_d = S_WW;
      end
      S_WW: state_d = S_WM;
      S_WM: begin
        cmd_o.mem_we = 1'b1;
        state_d = S_DN;
      end
      S_PX0: begin
        cmd_o.fb_rd_pix = 1'b1;
        state_d = S_PX1;
      end
      S_PX1: begin
        cmd_o.cap_pix = 1'b1;
        state_d = S_DN;
      end
      S_F0A: begin
        cmd_o.am_load = 1'b1;
        cmd_o.am_sel  = c8ic_pkg::AM_PC;
        state_d = S_F0W;
      end
      S_F0W: state_d = S_F0M;
      S_F0M: begin
        cmd_o.mem_re = 1'b1;
        state_d = S_F1A;
      end
      S_F1A: begin
        cmd_o.cap_hi  = 1'b1;
        cmd_o.am_load = 1'b1;
        cmd_o.am_sel  = c8ic_pkg::AM_PC1;
        state_d = S_F1W;
      end
      S_F1W: state_d = S_F1M;
      S_F1M: begin
        cmd_o.mem_re = 1'b1;
        state_d = S_FLO;
      end
      S_FLO: begin
        cmd_o.cap_lo = 1'b1;
        state_d = S_RX;
      end
      S_RX: begin
        cmd_o.rf_re = 1'b1;
        state_d = S_RY;
      end
      S_RY: begin
        cmd_o.cap_vx = 1'b1;
        cmd_o.rf_re  = 1'b1;
        cmd_o.rf_sel = c8ic_pkg::RS_Y;
        state_d = S_RV;
      end
      S_RV: begin
        cmd_o.cap_vy = 1'b1;
        state_d = S_EX;
      end
      S_EX: begin
        cmd_o.exec    = 1'b1;
        cmd_o.cnt_clr = 1'b1;
        case (stat_i.kind)
          c8ic_pkg::K_RET: state_d = S_RT;
          c8ic_pkg::K_ALU: state_d = stat_i.alu_flag ? S_AF : S_TK;
          c8ic_pkg::K_BCD: state_d = S_BA;
          c8ic_pkg::K_STR: state_d = S_SA;
          c8ic_pkg::K_LDR: state_d = S_LA;
          c8ic_pkg::K_DRW: state_d = stat_i.n_zero ? S_DE : S_DA;
          default:         state_d = S_TK;
        endcase
      end
      S_RT: begin
        cmd_o.ret_load = 1'b1;
        state_d = S_TK;
      end
      S_AF: begin
        cmd_o.alu_flag_wr = 1'b1;
        state_d = S_TK;
      end
      S_BA: begin
        cmd_o.am_load = 1'b1;
        state_d = S_BW;
      end
      S_BW: state_d = S_BM;
      S_BM: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.mw_sel = c8ic_pkg::MW_BCD;
        if (stat_i.cnt_eq_2) begin
          state_d = S_TK;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d = S_BA;
        end
      end
      S_SA: begin
        cmd_o.am_load = 1'b1;
        cmd_o.rf_re   = 1'b1;
        cmd_o.rf_sel  = c8ic_pkg::RS_CNT;
        state_d = S_SW;
      end
      S_SW: state_d = S_SM;
      S_SM: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.mw_sel = c8ic_pkg::MW_REG;
        if (stat_i.cnt_eq_x) begin
          state_d = S_TK;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d = S_SA;
        end
      end
      S_LA: begin
        cmd_o.am_load = 1'b1;
        state_d = S_LW;
      end
      S_LW: state_d = S_LM;
      S_LM: begin
        cmd_o.mem_re = 1'b1;
        state_d = S_LR;
      end
      S_LR: begin
        cmd_o.ldr_wr = 1'b1;
        if (stat_i.cnt_eq_x) begin
          state_d = S_TK;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d = S_LA;
        end
      end
      S_DA: begin
        cmd_o.am_load = 1'b1;
        state_d = S_DW;
      end
      S_DW: state_d = S_DM;
      S_DM: begin
        cmd_o.mem_re     = 1'b1;
        cmd_o.fb_rd_draw = 1'b1;
        state_d = S_DX;
      end
      S_DX: begin
        cmd_o.draw_wr = 1'b1;
        if (stat_i.cnt_eq_nlast) begin
          state_d = S_DE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d = S_DA;
        end
      end
      S_DE: begin
        cmd_o.coll_wr = 1'b1;
        state_d = S_TK;
      end
      S_TK: begin
        cmd_o.tick = 1'b1;
        state_d = S_DN;
      end
      S_DN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/core/chip8_instruction_core.sv -----
// top level of the chip-8 instruction core
// depends on c8ic_pkg, c8ic_ctrl and c8ic_dpath
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+-----------------------------------
//   in      | input     | in_valid_i/in_ready_o   | operation, address, data, key_state
//   out     | output    | out_valid_o/out_ready_i | pc_value, fetched_opcode, pixel,
//           |           |                         | halted, drew, unknown_opcode
//
// one word at a time; each memory access passes through the address
// wrap unit (load, reciprocal multiply, subtract) on the single program memory port
// after reset the program memory is zeroed one byte a cycle, all MEM_BYTES bytes,
// with in_ready_o low
// a finished result waits in the output register and the next word is taken
// meanwhile; that next result is held back until the waiting one is accepted
module chip8_instruction_core #(
  parameter int unsigned MEM_BYTES   = c8ic_pkg::MemBytesDef,
  parameter int unsigned STACK_DEPTH = c8ic_pkg::StackDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [11:0] address_i,
  input  logic [7:0]  data_i,
  input  logic [15:0] key_state_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] pc_value_o,
  output logic [15:0] fetched_opcode_o,
  output logic        pixel_o,
  output logic        halted_o,
  output logic        drew_o,
  output logic        unknown_opcode_o
);

  // command and status between sequencer and datapath
  c8ic_pkg::cmd_t  cmd;
  c8ic_pkg::stat_t stat;

  c8ic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // memories, register file, stack, frame buffer and the result register
  c8ic_dpath #(
    .MEM_BYTES   (MEM_BYTES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .operation_i      (operation_i),
    .address_i        (address_i),
    .data_i           (data_i),
    .key_state_i      (key_state_i),
    .pc_value_o       (pc_value_o),
    .fetched_opcode_o (fetched_opcode_o),
    .pixel_o          (pixel_o),
    .halted_o         (halted_o),
    .drew_o           (drew_o),
    .unknown_opcode_o (unknown_opcode_o)
  );

endmodule
